FILE: hw/rtl/cop_pkg.sv
// Package for the cylinder overlap push-out unit: widths, payload and context types.
package cop_pkg;

    localparam int POS_W   = 24;
    localparam int DIM_W   = 20;
    localparam int RANGE_W = DIM_W + 1;
    localparam int MAG_W   = RANGE_W;
    localparam int VX_W    = POS_W + 1;
    localparam int VERT_W  = POS_W + 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int ROOT_W  = (D2_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int PROD_W  = MAG_W + RANGE_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int Q_W     = RANGE_W;
    localparam int DIV_W   = ROOT_W;
    localparam int SUM_W   = POS_W + 2;

    typedef struct packed {
        logic                    mode;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] a_z;
        logic [DIM_W-1:0]        a_radius;
        logic [DIM_W-1:0]        a_height;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic signed [POS_W-1:0] b_z;
        logic [DIM_W-1:0]        b_radius;
        logic [DIM_W-1:0]        b_height;
    } item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
    } result_t;

    // Per-item context that travels alongside the arithmetic pipeline.
    typedef struct packed {
        logic                    live;
        logic                    zero;
        logic                    neg_x;
        logic                    neg_z;
        logic [MAG_W-1:0]        mag_x;
        logic [MAG_W-1:0]        mag_z;
        logic [RANGE_W-1:0]      range_sum;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_z;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic signed [POS_W-1:0] b_z;
    } ctx_t;

endpackage

FILE: hw/rtl/cop_front.sv
// Front stages: vertical test, XZ offset, box test, squares and distance compare.
module cop_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid,
    input  cop_pkg::item_t              item,
    output logic                        d2_valid,
    output logic [cop_pkg::D2_W-1:0]    d2,
    output cop_pkg::ctx_t               ctx
);

    // Stage 1 signals
    logic signed [cop_pkg::VERT_W-1:0] ay, by, alo, ahi, btop, ar_e, ah_e, bh_e;
    logic signed [cop_pkg::VX_W-1:0]   vx, vz;
    logic                              vok;
    logic [cop_pkg::RANGE_W-1:0]       rng;

    logic                              v1_reg;
    logic                              vok1_reg;
    logic signed [cop_pkg::VX_W-1:0]   vx1_reg, vz1_reg;
    logic [cop_pkg::RANGE_W-1:0]       rng1_reg;
    cop_pkg::item_t                    it1_reg;

    // Stage 2 signals
    logic [cop_pkg::VX_W-1:0]          absx, absz;
    cop_pkg::ctx_t                     ctx2_next;
    logic                              v2_reg;
    cop_pkg::ctx_t                     ctx2_reg;

    // Stage 3 signals
    logic                              v3_reg;
    cop_pkg::ctx_t                     ctx3_reg;
    logic [cop_pkg::SQ_W-1:0]          sqx3_reg, sqz3_reg, rsq3_reg;

    // Stage 4 signals
    logic [cop_pkg::D2_W-1:0]          d2_next;
    cop_pkg::ctx_t                     ctx4_next;
    logic                              v4_reg;
    cop_pkg::ctx_t                     ctx4_reg;
    logic [cop_pkg::D2_W-1:0]          d24_reg;

    always_comb
    begin
        ay   = {{2{item.a_y[cop_pkg::POS_W-1]}}, item.a_y};
        by   = {{2{item.b_y[cop_pkg::POS_W-1]}}, item.b_y};
        ar_e = {{(cop_pkg::VERT_W-cop_pkg::DIM_W){1'b0}}, item.a_radius};
        ah_e = {{(cop_pkg::VERT_W-cop_pkg::DIM_W){1'b0}}, item.a_height};
        bh_e = {{(cop_pkg::VERT_W-cop_pkg::DIM_W){1'b0}}, item.b_height};
        alo  = item.mode ? (ay - ar_e) : ay;
        ahi  = item.mode ? (ay + ar_e) : (ay + ah_e);
        btop = by + bh_e;
        vok  = !(alo > btop) && !(ahi < by);
        vx   = {item.b_x[cop_pkg::POS_W-1], item.b_x} - {item.a_x[cop_pkg::POS_W-1], item.a_x};
        vz   = {item.b_z[cop_pkg::POS_W-1], item.b_z} - {item.a_z[cop_pkg::POS_W-1], item.a_z};
        rng  = {1'b0, item.a_radius} + {1'b0, item.b_radius};
    end

    always_comb
    begin
        absx = vx1_reg[cop_pkg::VX_W-1] ? (~vx1_reg + 1'b1) : vx1_reg;
        absz = vz1_reg[cop_pkg::VX_W-1] ? (~vz1_reg + 1'b1) : vz1_reg;
        ctx2_next.live  = vok1_reg
                        && (absx <= {{(cop_pkg::VX_W-cop_pkg::RANGE_W){1'b0}}, rng1_reg})
                        && (absz <= {{(cop_pkg::VX_W-cop_pkg::RANGE_W){1'b0}}, rng1_reg});
        ctx2_next.zero      = 1'b0;
        ctx2_next.neg_x     = vx1_reg[cop_pkg::VX_W-1];
        ctx2_next.neg_z     = vz1_reg[cop_pkg::VX_W-1];
        ctx2_next.mag_x     = absx[cop_pkg::MAG_W-1:0];
        ctx2_next.mag_z     = absz[cop_pkg::MAG_W-1:0];
        ctx2_next.range_sum = rng1_reg;
        ctx2_next.a_x       = it1_reg.a_x;
        ctx2_next.a_z       = it1_reg.a_z;
        ctx2_next.b_x       = it1_reg.b_x;
        ctx2_next.b_y       = it1_reg.b_y;
        ctx2_next.b_z       = it1_reg.b_z;
    end

    always_comb
    begin
        d2_next        = {1'b0, sqx3_reg} + {1'b0, sqz3_reg};
        ctx4_next      = ctx3_reg;
        ctx4_next.live = ctx3_reg.live && (d2_next <= {1'b0, rsq3_reg});
        ctx4_next.zero = (d2_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vok1_reg <= vok;
            vx1_reg  <= vx;
            vz1_reg  <= vz;
            rng1_reg <= rng;
            it1_reg  <= item;
            ctx2_reg <= ctx2_next;
            ctx3_reg <= ctx2_reg;
            sqx3_reg <= ctx2_reg.mag_x * ctx2_reg.mag_x;
            sqz3_reg <= ctx2_reg.mag_z * ctx2_reg.mag_z;
            rsq3_reg <= ctx2_reg.range_sum * ctx2_reg.range_sum;
            ctx4_reg <= ctx4_next;
            d24_reg  <= d2_next;
        end
    end

    assign d2_valid = v4_reg;
    assign d2       = d24_reg;
    assign ctx      = ctx4_reg;

endmodule

FILE: hw/rtl/cop_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module cop_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid,
    input  logic [cop_pkg::D2_W-1:0]     d2,
    input  cop_pkg::ctx_t                ctx,
    output logic                         root_valid,
    output logic [cop_pkg::ROOT_W-1:0]   root,
    output cop_pkg::ctx_t                root_ctx
);

    localparam int N = cop_pkg::ROOT_W;

    logic                          v_reg   [N];
    logic [cop_pkg::REM_W-1:0]     rem_reg [N];
    logic [cop_pkg::ROOT_W-1:0]    rt_reg  [N];
    logic [cop_pkg::RAD_W-1:0]     rad_reg [N];
    cop_pkg::ctx_t                 ctx_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic                       v_in;
        logic [cop_pkg::REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [cop_pkg::ROOT_W-1:0] rt_in, rt_next;
        logic [cop_pkg::RAD_W-1:0]  rad_in;
        cop_pkg::ctx_t              ctx_in;
        logic                       ge;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                v_in   = valid;
                rem_in = '0;
                rt_in  = '0;
                rad_in = {{(cop_pkg::RAD_W-cop_pkg::D2_W){1'b0}}, d2};
                ctx_in = ctx;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in   = v_reg[g-1];
                rem_in = rem_reg[g-1];
                rt_in  = rt_reg[g-1];
                rad_in = rad_reg[g-1];
                ctx_in = ctx_reg[g-1];
            end
        end

        always_comb
        begin
            rem_sh   = {rem_in[cop_pkg::REM_W-3:0], rad_in[cop_pkg::RAD_W-1-2*g -: 2]};
            trial    = {rt_in, 2'b01};
            ge       = (rem_sh >= trial);
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            rt_next  = {rt_in[cop_pkg::ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                rt_reg[g]  <= rt_next;
                rad_reg[g] <= rad_in;
                ctx_reg[g] <= ctx_in;
            end
        end
    end

    assign root_valid = v_reg[N-1];
    assign root       = rt_reg[N-1];
    assign root_ctx   = ctx_reg[N-1];

endmodule

FILE: hw/rtl/cop_div.sv
// Scaling multiply and two-lane pipelined restoring divider for the push distance.
module cop_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid,
    input  logic [cop_pkg::ROOT_W-1:0]  root,
    input  cop_pkg::ctx_t               ctx,
    output logic                        q_valid,
    output logic [cop_pkg::Q_W-1:0]     q_x,
    output logic [cop_pkg::Q_W-1:0]     q_z,
    output cop_pkg::ctx_t               q_ctx
);

    localparam int N = cop_pkg::Q_W;

    // Multiply stage: numerator = |v| * range + floor(d / 2).
    logic                          vm_reg;
    logic [cop_pkg::NUM_W-1:0]     num_reg [2];
    logic [cop_pkg::DIV_W-1:0]     dm_reg;
    cop_pkg::ctx_t                 ctxm_reg;
    logic [cop_pkg::PROD_W-1:0]    prod_x, prod_z;
    logic [cop_pkg::NUM_W-1:0]     half;

    logic                          v_reg   [N];
    logic [cop_pkg::DIV_W-1:0]     rem_reg [N][2];
    logic [cop_pkg::Q_W-1:0]       lo_reg  [N][2];
    logic [cop_pkg::Q_W-1:0]       q_reg   [N][2];
    logic [cop_pkg::DIV_W-1:0]     d_reg   [N];
    cop_pkg::ctx_t                 ctx_reg [N];

    always_comb
    begin
        prod_x = ctx.mag_x * ctx.range_sum;
        prod_z = ctx.mag_z * ctx.range_sum;
        half   = cop_pkg::NUM_W'(root[cop_pkg::ROOT_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= {1'b0, prod_x} + half;
            num_reg[1] <= {1'b0, prod_z} + half;
            dm_reg     <= root;
            ctxm_reg   <= ctx;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic                       v_in;
        logic [cop_pkg::DIV_W-1:0]  d_in;
        cop_pkg::ctx_t              ctx_in;
        logic [cop_pkg::DIV_W-1:0]  rem_in  [2];
        logic [cop_pkg::Q_W-1:0]    lo_in   [2];
        logic [cop_pkg::Q_W-1:0]    q_in    [2];
        logic [cop_pkg::DIV_W:0]    sh      [2];
        logic [cop_pkg::DIV_W:0]    diff    [2];
        logic [cop_pkg::DIV_W-1:0]  rem_nx  [2];
        logic [cop_pkg::Q_W-1:0]    q_nx    [2];

        if (g == 0)
        begin : g_first
            always_comb
            begin
                v_in   = vm_reg;
                d_in   = dm_reg;
                ctx_in = ctxm_reg;
                for (int l = 0; l < 2; l++)
                begin
                    rem_in[l] = cop_pkg::DIV_W'(num_reg[l] >> cop_pkg::Q_W);
                    lo_in[l]  = num_reg[l][cop_pkg::Q_W-1:0];
                    q_in[l]   = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in   = v_reg[g-1];
                d_in   = d_reg[g-1];
                ctx_in = ctx_reg[g-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_in[l] = rem_reg[g-1][l];
                    lo_in[l]  = lo_reg[g-1][l];
                    q_in[l]   = q_reg[g-1][l];
                end
            end
        end

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                sh[l]     = {rem_in[l], lo_in[l][N-1-g]};
                diff[l]   = sh[l] - {1'b0, d_in};
                rem_nx[l] = (sh[l] >= {1'b0, d_in}) ? diff[l][cop_pkg::DIV_W-1:0]
                                                    : sh[l][cop_pkg::DIV_W-1:0];
                q_nx[l]   = {q_in[l][cop_pkg::Q_W-2:0], (sh[l] >= {1'b0, d_in})};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[g]   <= d_in;
                ctx_reg[g] <= ctx_in;
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[g][l] <= rem_nx[l];
                    lo_reg[g][l]  <= lo_in[l];
                    q_reg[g][l]   <= q_nx[l];
                end
            end
        end
    end

    assign q_valid = v_reg[N-1];
    assign q_x     = q_reg[N-1][0];
    assign q_z     = q_reg[N-1][1];
    assign q_ctx   = ctx_reg[N-1];

endmodule

FILE: hw/rtl/cylinder_overlap_pushout_unit.sv
// Top level of the cylinder overlap push-out unit: pipeline assembly and output register.
//
// Usage: shape A (upright cylinder when mode is 0, sphere when mode is 1) and
// upright cylinder B arrive as one item_t transfer on item_valid/item_ready.
// Each item produces exactly one result_t transfer on result_valid/result_ready:
// hit plus the position of B, pushed out in XZ to the sum of the radii when the
// shapes overlap, otherwise B unchanged. out_y is always B's y.
// Throughput: one item per cycle while results are taken. From the input transfer
// to result_valid an item passes 4 front stages (offset, box test, squares,
// distance compare), 22 square root stages (one root bit each), 1 scaling
// multiply stage, 21 divider stages (one quotient bit each) and the output
// register with rounding sign, offset add and saturation.
// Reset clears every valid bit in the pipeline, so no result appears until an
// item is accepted. When the receiver stalls with a result waiting, the whole
// pipeline holds in place and item_ready drops; nothing is lost or repeated,
// and the pipeline moves again in the cycle the waiting result is taken.
module cylinder_overlap_pushout_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  cop_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output cop_pkg::result_t  result
);

    logic                           pipe_en;
    logic                           fr_valid;
    logic [cop_pkg::D2_W-1:0]       fr_d2;
    cop_pkg::ctx_t                  fr_ctx;
    logic                           sq_valid;
    logic [cop_pkg::ROOT_W-1:0]     sq_root;
    cop_pkg::ctx_t                  sq_ctx;
    logic                           dv_valid;
    logic [cop_pkg::Q_W-1:0]        dv_qx, dv_qz;
    cop_pkg::ctx_t                  dv_ctx;

    logic signed [cop_pkg::SUM_W-1:0] off_x, off_z, sum_x, sum_z;
    cop_pkg::result_t                 result_next;
    logic                             result_valid_reg;
    cop_pkg::result_t                 result_reg;

    // Clamp a widened sum to the signed position range.
    function automatic logic signed [cop_pkg::POS_W-1:0] sat_pos(
        input logic signed [cop_pkg::SUM_W-1:0] v
    );
        logic signed [cop_pkg::SUM_W-1:0] hi, lo;
        hi = {{(cop_pkg::SUM_W-cop_pkg::POS_W+1){1'b0}}, {(cop_pkg::POS_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            sat_pos = hi[cop_pkg::POS_W-1:0];
        else if (v < lo)
            sat_pos = lo[cop_pkg::POS_W-1:0];
        else
            sat_pos = v[cop_pkg::POS_W-1:0];
    endfunction

    // The pipeline advances whenever the output register is empty or being drained.
    assign pipe_en    = !result_valid_reg || result_ready;
    assign item_ready = pipe_en;

    cop_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .valid    (item_valid),
        .item     (item),
        .d2_valid (fr_valid),
        .d2       (fr_d2),
        .ctx      (fr_ctx)
    );

    cop_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .valid      (fr_valid),
        .d2         (fr_d2),
        .ctx        (fr_ctx),
        .root_valid (sq_valid),
        .root       (sq_root),
        .root_ctx   (sq_ctx)
    );

    cop_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .valid   (sq_valid),
        .root    (sq_root),
        .ctx     (sq_ctx),
        .q_valid (dv_valid),
        .q_x     (dv_qx),
        .q_z     (dv_qz),
        .q_ctx   (dv_ctx)
    );

    // A zero offset pushes B along +x by the full radius sum; otherwise the
    // rounded quotient magnitude takes the sign of the offset.
    always_comb
    begin
        if (dv_ctx.zero)
        begin
            off_x = {{(cop_pkg::SUM_W-cop_pkg::RANGE_W){1'b0}}, dv_ctx.range_sum};
            off_z = '0;
        end
        else
        begin
            off_x = {{(cop_pkg::SUM_W-cop_pkg::Q_W){1'b0}}, dv_qx};
            off_z = {{(cop_pkg::SUM_W-cop_pkg::Q_W){1'b0}}, dv_qz};
            if (dv_ctx.neg_x)
                off_x = -off_x;
            if (dv_ctx.neg_z)
                off_z = -off_z;
        end
        sum_x = {{2{dv_ctx.a_x[cop_pkg::POS_W-1]}}, dv_ctx.a_x} + off_x;
        sum_z = {{2{dv_ctx.a_z[cop_pkg::POS_W-1]}}, dv_ctx.a_z} + off_z;

        result_next.hit   = dv_ctx.live;
        result_next.out_y = dv_ctx.b_y;
        result_next.out_x = dv_ctx.live ? sat_pos(sum_x) : dv_ctx.b_x;
        result_next.out_z = dv_ctx.live ? sat_pos(sum_z) : dv_ctx.b_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (pipe_en)
            result_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/cop_checker.sv
// Port-level checker for the cylinder overlap push-out unit, with its bind.
module cop_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input cop_pkg::item_t    item,
    input logic              result_valid,
    input logic              result_ready,
    input cop_pkg::result_t  result
);

    // A waiting result holds until the transfer completes.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The input side is open exactly when the output register can move.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("item_ready does not follow the output stall");

    // Reset empties the pipeline, so no result is offered right after a reset edge.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result offered during reset");

    // A result only leaves the output once it has been taken.
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result dropped without a transfer");

    // An offered item stays put until the unit takes it.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item changed while waiting");

endmodule

bind cylinder_overlap_pushout_unit cop_checker u_cop_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

FILE: tb/testbench.sv
// Testbench for the cylinder overlap push-out unit: random and directed pairs checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int N_RANDOM    = 1830;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    cop_pkg::item_t    item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    cop_pkg::result_t  result;

    // Pairs waiting to be driven, and the push-out results still owed by the unit.
    cop_pkg::item_t    pending_pairs[$];
    cop_pkg::result_t  owed_pushouts[$];

    int      errors = 0;
    int      cycles = 0;
    bit      stimulus_done = 1'b0;
    bit      quiet_tail = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    always #6 clk = ~clk;

    cylinder_overlap_pushout_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    function automatic logic signed [cop_pkg::POS_W-1:0] clamp_pos(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (cop_pkg::POS_W - 1)) - 1;
        lo = -(64'sd1 <<< (cop_pkg::POS_W - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[cop_pkg::POS_W-1:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Signed offset scaled to the push distance, magnitude rounded half away from zero.
    function automatic longint scaled_offset(longint v, longint unsigned span,
                                             longint unsigned root_d);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        q = (mag * span + (root_d >> 1)) / root_d;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic cop_pkg::result_t predict_pushout(cop_pkg::item_t p);
        cop_pkg::result_t r;
        longint           ax, ay, az, bx, by, bz, ar, ah, br, bh;
        longint           lo, hi, vx, vz, span;
        longint unsigned  d2, root_d;
        bit               overlap;
        ax = p.a_x; ay = p.a_y; az = p.a_z;
        bx = p.b_x; by = p.b_y; bz = p.b_z;
        ar = p.a_radius; ah = p.a_height;
        br = p.b_radius; bh = p.b_height;
        // A sphere spans its radius up and down; a cylinder rises from its base.
        if (p.mode)
        begin
            lo = ay - ar;
            hi = ay + ar;
        end
        else
        begin
            lo = ay;
            hi = ay + ah;
        end
        overlap = !(lo > by + bh || hi < by);
        vx = bx - ax;
        vz = bz - az;
        span = ar + br;
        d2 = vx * vx + vz * vz;
        if (overlap && d2 > span * span)
            overlap = 1'b0;
        r.out_y = p.b_y;
        if (!overlap)
        begin
            r.hit = 1'b0;
            r.out_x = p.b_x;
            r.out_z = p.b_z;
        end
        else
        begin
            r.hit = 1'b1;
            if (d2 == 0)
            begin
                // Coincident centers push B along +x.
                r.out_x = clamp_pos(ax + span);
                r.out_z = p.a_z;
            end
            else
            begin
                root_d = root_floor(d2);
                r.out_x = clamp_pos(ax + scaled_offset(vx, span, root_d));
                r.out_z = clamp_pos(az + scaled_offset(vz, span, root_d));
            end
        end
        return r;
    endfunction

    function automatic logic signed [cop_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(cop_pkg::POS_W-1){1'b0}}};
            1: return {1'b0, {(cop_pkg::POS_W-1){1'b1}}};
            default: return cop_pkg::POS_W'($urandom());
        endcase
    endfunction

    // Builds a pair whose shapes are close, so most pairs reach the push-out path.
    function automatic cop_pkg::item_t near_pair();
        cop_pkg::item_t p;
        int             reach;
        p = '0;
        p.mode = 1'($urandom_range(0, 1));
        reach = 1 << $urandom_range(2, 20);
        p.a_radius = cop_pkg::DIM_W'($urandom_range(0, reach - 1));
        p.b_radius = cop_pkg::DIM_W'($urandom_range(0, reach - 1));
        p.a_height = cop_pkg::DIM_W'($urandom_range(0, reach - 1));
        p.b_height = cop_pkg::DIM_W'($urandom_range(0, reach - 1));
        p.a_x = ($urandom_range(0, 7) == 0) ? rand_pos()
                                            : cop_pkg::POS_W'($signed($urandom()) >>> 2);
        p.a_y = cop_pkg::POS_W'($signed($urandom()) >>> 2);
        p.a_z = cop_pkg::POS_W'($signed($urandom()) >>> 2);
        p.b_x = cop_pkg::POS_W'(int'(p.a_x) + int'($urandom_range(0, 4 * reach)) - 2 * reach);
        p.b_y = cop_pkg::POS_W'(int'(p.a_y) + int'($urandom_range(0, 2 * reach)) - reach);
        p.b_z = cop_pkg::POS_W'(int'(p.a_z) + int'($urandom_range(0, 4 * reach)) - 2 * reach);
        if ($urandom_range(0, 15) == 0)
            p.b_z = p.a_z;
        return p;
    endfunction

    // Reset is released once; stimulus is queued up front.
    initial
    begin
        cop_pkg::item_t p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, touching contacts, coincident centers and saturation.
        p = '0;
        pending_pairs.push_back(p);
        p.mode = 1'b1;
        pending_pairs.push_back(p);
        p = '0;
        p.a_radius = '1; p.b_radius = '1; p.a_height = '1; p.b_height = '1;
        pending_pairs.push_back(p);
        p.a_x = {1'b0, {(cop_pkg::POS_W-1){1'b1}}}; p.b_x = p.a_x;
        pending_pairs.push_back(p);
        p.a_x = {1'b1, {(cop_pkg::POS_W-1){1'b0}}};
        p.b_x = cop_pkg::POS_W'(int'(p.a_x) + 1);
        p.a_z = {1'b0, {(cop_pkg::POS_W-1){1'b1}}};
        p.b_z = cop_pkg::POS_W'(int'(p.a_z) - 1);
        pending_pairs.push_back(p);
        p = '0;
        p.a_radius = 100; p.b_radius = 50; p.b_x = 150;
        pending_pairs.push_back(p);
        p.b_x = 151;
        pending_pairs.push_back(p);
        p.b_x = -90; p.b_z = 120;
        pending_pairs.push_back(p);
        p.a_height = 10; p.b_y = 10;
        pending_pairs.push_back(p);
        p.b_y = 11;
        pending_pairs.push_back(p);
        p.b_y = -5; p.b_height = 5;
        pending_pairs.push_back(p);
        p.b_height = 4;
        pending_pairs.push_back(p);
        p.mode = 1'b1; p.a_y = 200; p.b_y = 100; p.b_height = 0;
        pending_pairs.push_back(p);
        p.b_height = 0; p.b_y = 301;
        pending_pairs.push_back(p);
        p.b_y = 300;
        pending_pairs.push_back(p);
        p = '1;
        pending_pairs.push_back(p);
        p = '1; p.mode = 1'b0;
        pending_pairs.push_back(p);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                p = near_pair();
            else
            begin
                p = {1'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom()};
            end
            pending_pairs.push_back(p);
        end
        stimulus_done = 1'b1;
    end

    // Driver: holds each pair until it is taken, with random bursts of idle cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                owed_pushouts.push_back(predict_pushout(item));
            if (item_valid && !item_ready)
                ;
            else if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                item_valid <= 1'b1;
                item <= pending_pairs.pop_front();
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 10);
            end
            else
                item_valid <= 1'b0;
            quiet_tail <= stimulus_done && pending_pairs.size() < 300;
        end
    end

    // Monitor: checks every result transfer and stalls the receiver in bursts.
    always @(posedge clk)
    begin
        cop_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (owed_pushouts.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %p", $time, result);
                    errors++;
                end
                else
                begin
                    want = owed_pushouts.pop_front();
                    if (result.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d", $time, want.hit, result.hit);
                        errors++;
                    end
                    if (result.out_x !== want.out_x)
                    begin
                        $display("%0t: out_x expected %0d actual %0d",
                                 $time, want.out_x, result.out_x);
                        errors++;
                    end
                    if (result.out_y !== want.out_y)
                    begin
                        $display("%0t: out_y expected %0d actual %0d",
                                 $time, want.out_y, result.out_y);
                        errors++;
                    end
                    if (result.out_z !== want.out_z)
                    begin
                        $display("%0t: out_z expected %0d actual %0d",
                                 $time, want.out_z, result.out_z);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                result_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 10);
            end
        end
    end

    // Finish once everything is drained plus a margin past the pipeline latency.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            if (stimulus_done && pending_pairs.size() == 0 && !item_valid
                && owed_pushouts.size() == 0)
                break;
        end
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
